// ----- sv/npma_pkg.sv -----
package npma_pkg;

    localparam int INDEX_BITS = 8;
    localparam int KIND_BITS = 3;

    localparam logic [KIND_BITS-1:0] KIND_LOAD_A = 3'd0;
    localparam logic [KIND_BITS-1:0] KIND_LOAD_B = 3'd1;
    localparam logic [KIND_BITS-1:0] KIND_MAC = 3'd2;
    localparam logic [KIND_BITS-1:0] KIND_CLEAR = 3'd3;
    localparam logic [KIND_BITS-1:0] KIND_READ = 3'd4;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic host_read;
        logic clr_step;
        logic mac_step;
    } cmd_t;

    typedef struct packed {
        logic j_last;
        logic i_last;
        logic pipe_busy;
    } status_t;

endpackage

// ----- sv/npma_ctrl.sv -----
module npma_ctrl
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [npma_pkg::KIND_BITS-1:0] kind,
    input  npma_pkg::status_t              status,
    output npma_pkg::cmd_t                 cmd,
    output logic                           busy,
    output logic                           done,
    output logic [npma_pkg::KIND_BITS-1:0] done_kind
);

    typedef enum logic [4:0] {
        ST_INIT  = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_CLEAR = 5'b00100,
        ST_MAC   = 5'b01000,
        ST_DRAIN = 5'b10000
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic                             done_reg;
    logic                             done_next;
    logic [npma_pkg::KIND_BITS-1:0]   kind_reg;
    logic                             accept;

    assign busy = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);
    assign done = done_reg;
    assign done_kind = kind_reg;

    always_comb
    begin
        state_next = state_reg;
        done_next = 1'b0;
        cmd = '0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (status.j_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (kind)
                        npma_pkg::KIND_LOAD_A:
                        begin
                            cmd.load_a = 1'b1;
                            done_next = 1'b1;
                        end
                        npma_pkg::KIND_LOAD_B:
                        begin
                            cmd.load_b = 1'b1;
                            done_next = 1'b1;
                        end
                        npma_pkg::KIND_READ:
                        begin
                            cmd.host_read = 1'b1;
                            done_next = 1'b1;
                        end
                        npma_pkg::KIND_MAC:
                        begin
                            state_next = ST_MAC;
                        end
                        npma_pkg::KIND_CLEAR:
                        begin
                            state_next = ST_CLEAR;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.j_last)
                begin
                    state_next = ST_IDLE;
                    done_next = 1'b1;
                end
            end
            ST_MAC:
            begin
                cmd.mac_step = 1'b1;
                if (status.j_last && status.i_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_IDLE;
                    done_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
        end
    end

endmodule

// ----- sv/npma_datapath.sv -----
module npma_datapath
#(
    parameter int DEGREE = 256,
    parameter int COEF_BITS = 13
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  npma_pkg::cmd_t                  cmd,
    input  logic [npma_pkg::INDEX_BITS-1:0] index,
    input  logic [COEF_BITS-1:0]            value,
    output npma_pkg::status_t               status,
    output logic [COEF_BITS-1:0]            read_data
);

    localparam int AW = $clog2(DEGREE);
    localparam logic [AW-1:0] LAST = AW'(DEGREE - 1);
    localparam logic [AW:0] DEG_W = (AW + 1)'(DEGREE);

    logic [COEF_BITS-1:0]   a_mem [DEGREE];
    logic [COEF_BITS-1:0]   b_mem [DEGREE];
    logic [COEF_BITS-1:0]   acc_mem [DEGREE];

    logic [AW-1:0]          i_reg;
    logic [AW-1:0]          i_next;
    logic [AW-1:0]          j_reg;
    logic [AW-1:0]          j_next;
    logic                   v1_reg;
    logic                   v2_reg;
    logic [AW-1:0]          k1_reg;
    logic [AW-1:0]          k2_reg;
    logic                   neg1_reg;
    logic                   neg2_reg;
    logic [COEF_BITS-1:0]   a_rd_reg;
    logic [COEF_BITS-1:0]   b_rd_reg;
    logic [COEF_BITS-1:0]   acc_rd_reg;
    logic [COEF_BITS-1:0]   prod_reg;
    logic                   rd_ok_reg;

    logic [AW-1:0]          idx_addr;
    logic                   idx_ok;
    logic [AW:0]            k_sum;
    logic                   k_wrap;
    logic [AW-1:0]          k0;
    logic [COEF_BITS-1:0]   full_prod;
    logic [COEF_BITS-1:0]   acc_sum;
    logic [AW-1:0]          acc_raddr;
    logic                   acc_we;
    logic [AW-1:0]          acc_waddr;
    logic [COEF_BITS-1:0]   acc_wdata;

    assign idx_addr = AW'(index);
    assign idx_ok = (32'(index) < DEGREE);

    assign k_sum = {1'b0, i_reg} + {1'b0, j_reg};
    assign k_wrap = (k_sum >= DEG_W);
    assign k0 = k_wrap ? AW'(k_sum - DEG_W) : AW'(k_sum);

    assign full_prod = a_rd_reg * b_rd_reg;
    assign acc_sum = neg2_reg ? (acc_rd_reg - prod_reg) : (acc_rd_reg + prod_reg);

    assign acc_raddr = v1_reg ? k1_reg : idx_addr;
    assign acc_we = cmd.clr_step || v2_reg;
    assign acc_waddr = cmd.clr_step ? j_reg : k2_reg;
    assign acc_wdata = cmd.clr_step ? '0 : acc_sum;

    assign status.j_last = (j_reg == LAST);
    assign status.i_last = (i_reg == LAST);
    assign status.pipe_busy = v1_reg || v2_reg;

    assign read_data = rd_ok_reg ? acc_rd_reg : '0;

    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        if (cmd.clr_step || cmd.mac_step)
        begin
            j_next = (j_reg == LAST) ? '0 : j_reg + 1'b1;
        end
        if (cmd.mac_step && (j_reg == LAST))
        begin
            i_next = (i_reg == LAST) ? '0 : i_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            i_reg <= i_next;
            j_reg <= j_next;
            v1_reg <= cmd.mac_step;
            v2_reg <= v1_reg;
            rd_ok_reg <= cmd.host_read && idx_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        k1_reg <= k0;
        neg1_reg <= k_wrap;
        k2_reg <= k1_reg;
        neg2_reg <= neg1_reg;
        prod_reg <= full_prod;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_a && idx_ok)
        begin
            a_mem[idx_addr] <= value;
        end
        a_rd_reg <= a_mem[i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b && idx_ok)
        begin
            b_mem[idx_addr] <= value;
        end
        b_rd_reg <= b_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (acc_we)
        begin
            acc_mem[acc_waddr] <= acc_wdata;
        end
        acc_rd_reg <= acc_mem[acc_raddr];
    end

endmodule

// ----- sv/negacyclic_poly_mul_acc.sv -----
// Multiply-accumulate of two polynomials modulo x^DEGREE + 1 with coefficients
// modulo 2^COEF_BITS. An item is taken when start is high and busy is low, and its
// result appears on done, done_kind and read_value for exactly one cycle; the
// receiver cannot stall it. Loads, reads and unused kinds return in the cycle after
// acceptance and may be issued every cycle. A clear keeps busy high while it sweeps
// the accumulator to zero and returns when the sweep ends. A multiply-accumulate
// runs one coefficient product per cycle through a single multiplier and a
// read-modify-write of the accumulator memory, and returns once the last product
// has left that pipeline. After reset the block sweeps the accumulator to zero
// with busy high before it takes its first item.
module negacyclic_poly_mul_acc
#(
    parameter int DEGREE = 256,
    parameter int COEF_BITS = 13
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [npma_pkg::KIND_BITS-1:0]  kind,
    input  logic [npma_pkg::INDEX_BITS-1:0] index,
    input  logic [COEF_BITS-1:0]            value,
    output logic                            busy,
    output logic                            done,
    output logic [COEF_BITS-1:0]            read_value,
    output logic [npma_pkg::KIND_BITS-1:0]  done_kind
);

    npma_pkg::cmd_t    cmd;
    npma_pkg::status_t status;

    npma_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .kind      (kind),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy),
        .done      (done),
        .done_kind (done_kind)
    );

    npma_datapath
    #(
        .DEGREE    (DEGREE),
        .COEF_BITS (COEF_BITS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .index     (index),
        .value     (value),
        .status    (status),
        .read_data (read_value)
    );

endmodule

// ----- sv/npma_checker.sv -----
module npma_checker
#(
    parameter int COEF_BITS = 13
)
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            start,
    input logic [npma_pkg::KIND_BITS-1:0]  kind,
    input logic                            busy,
    input logic                            done,
    input logic [COEF_BITS-1:0]            read_value,
    input logic [npma_pkg::KIND_BITS-1:0]  done_kind
);

    logic accept;
    logic quick;

    assign accept = start && !busy;
    assign quick = (kind != npma_pkg::KIND_MAC) && (kind != npma_pkg::KIND_CLEAR);

    // Only a read beat may carry a nonzero coefficient.
    a_read_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !(done && done_kind == npma_pkg::KIND_READ) |-> read_value == '0)
        else $error("read_value nonzero outside a read beat");

    a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && quick |=> done && done_kind == $past(kind))
        else $error("single-cycle item did not complete on the next cycle");

    a_long_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !quick |=> busy && !done)
        else $error("clear or multiply-accumulate did not hold busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while busy");

endmodule

bind negacyclic_poly_mul_acc npma_checker
#(
    .COEF_BITS (COEF_BITS)
)
u_npma_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .kind       (kind),
    .busy       (busy),
    .done       (done),
    .read_value (read_value),
    .done_kind  (done_kind)
);
